### hw/rtl/byte_weighted_lru_cache_core_defines.svh
// Assertion macros shared by the cache core.
`ifndef BYTE_WEIGHTED_LRU_CACHE_CORE_DEFINES_SVH
`define BYTE_WEIGHTED_LRU_CACHE_CORE_DEFINES_SVH

// Condition implies a consequence in the same cycle.
`define BWLRU_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Condition implies a consequence in the next cycle.
`define BWLRU_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/bwlru_pkg.sv
`default_nettype none
package bwlru_pkg;
    localparam int ENTRIES     = 16;
    localparam int TAG_BITS    = 64;
    localparam int HANDLE_BITS = 32;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int BYTES_W     = 25;
    localparam int TOT_W       = BYTES_W + IDX_W + 1;
    localparam int CAP_W       = 32;
    localparam int CMP_W       = (TOT_W > CAP_W) ? TOT_W : CAP_W;
    localparam int EVC_W       = 5;

    localparam logic FN_GET = 1'b0;
    localparam logic FN_PUT = 1'b1;

    typedef struct packed {
        logic        func;
        logic [63:0] key_tag;
        logic [24:0] item_bytes;
        logic [31:0] payload_handle;
    } t_in_item;

    typedef struct packed {
        logic        hit;
        logic [31:0] payload_out;
        logic        ignored;
        logic [4:0]  evicted_count;
        logic [31:0] bytes_in_use;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
    } t_out_item;

    typedef struct packed {
        logic [TAG_BITS-1:0]    tag;
        logic [BYTES_W-1:0]     nbytes;
        logic [HANDLE_BITS-1:0] handle;
        logic [IDX_W-1:0]       rank;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPD,
        ST_EVCHK,
        ST_EVRD,
        ST_PURGE,
        ST_DONE
    } t_state;
endpackage
`default_nettype wire

### hw/rtl/byte_weighted_lru_cache_core.sv
`default_nettype none
`include "byte_weighted_lru_cache_core_defines.svh"
// Byte-budgeted LRU cache core. One operation is handled at a time; each
// transfer on the input channel yields exactly one result transfer. Entry
// metadata (tag, size, handle, recency rank) lives in one RAM with a single
// read port, so every operation but an oversized put walks that RAM: a get
// miss does a tag scan plus decision, a get hit a scan and then a rank
// rewrite pass, and a put a scan, a rank rewrite, a budget eviction loop,
// then a pass that retires evicted slots. A put larger than the capacity
// goes straight to its result. Recency ranks are kept dense (0 = newest), so
// budget eviction reads sizes back from a second small RAM indexed by rank.
// A new result can wait in the output register while the next item is taken.
// The capacity register may be written only while the core is idle.
module byte_weighted_lru_cache_core import bwlru_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire t_in_item    i_in_data,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output t_out_item        o_out_data,
    input  wire logic        i_out_stall,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata
);
    t_state                 r_state, n_state;
    logic [ENTRIES-1:0]     r_valid, n_valid;
    logic [CAP_W-1:0]       r_cap;
    logic [TOT_W-1:0]       r_total, n_total;
    logic [31:0]            r_hit_cnt, n_hit_cnt, r_miss_cnt, n_miss_cnt;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out, n_out;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic                   r_pv, n_pv;
    logic [IDX_W-1:0]       r_pa, n_pa;
    t_in_item               r_item, n_item;
    logic                   r_found, n_found;
    logic [IDX_W-1:0]       r_ms, n_ms, r_mrank, n_mrank;
    logic [BYTES_W-1:0]     r_mbytes, n_mbytes, r_vbytes, n_vbytes;
    logic [HANDLE_BITS-1:0] r_mhandle, n_mhandle;
    logic                   r_free_found, n_free_found;
    logic [IDX_W-1:0]       r_free, n_free, r_vslot, n_vslot, r_slot, n_slot;
    logic [CNT_W-1:0]       r_cnt, n_cnt, r_ref, n_ref, r_k, n_k, r_keep, n_keep;
    logic [EVC_W-1:0]       r_evc, n_evc;
    logic                   r_ignored, n_ignored, r_hit, n_hit;

    // RAM ports
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    t_entry             ram_wdata, ram_rdata;
    logic               brk_we;
    logic [IDX_W-1:0]   brk_waddr, brk_raddr;
    logic [BYTES_W-1:0] brk_wdata, brk_rdata;

    logic             sweep_end, cur_v, full;
    logic [IDX_W-1:0] new_rank;

    bwlru_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sizes by recency rank, refreshed on each put's rank rewrite pass.
    bwlru_ram #(.WIDTH(BYTES_W), .DEPTH(ENTRIES)) u_rank_bytes_ram (
        .i_clk   (i_clk),
        .i_we    (brk_we),
        .i_waddr (brk_waddr),
        .i_wdata (brk_wdata),
        .i_raddr (brk_raddr),
        .o_rdata (brk_rdata)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A sweep is over once every address is issued and the last read is consumed.
    assign sweep_end = (r_idx == CNT_W'(ENTRIES)) && !r_pv;
    assign cur_v     = r_valid[r_pa];
    assign full      = (r_cnt == CNT_W'(ENTRIES)) && !r_found;
    // Entries newer than the reference rank age by one; the rest hold.
    assign new_rank  = ({1'b0, ram_rdata.rank} < r_ref) ? ram_rdata.rank + 1'b1
                                                         : ram_rdata.rank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_cap       <= CAP_W'(67108864);
            r_total     <= '0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_total     <= n_total;
            r_hit_cnt   <= n_hit_cnt;
            r_miss_cnt  <= n_miss_cnt;
            r_out_valid <= n_out_valid;
            r_pv        <= n_pv;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out        <= n_out;
        r_idx        <= n_idx;
        r_pa         <= n_pa;
        r_item       <= n_item;
        r_found      <= n_found;
        r_ms         <= n_ms;
        r_mrank      <= n_mrank;
        r_mbytes     <= n_mbytes;
        r_mhandle    <= n_mhandle;
        r_free_found <= n_free_found;
        r_free       <= n_free;
        r_vslot      <= n_vslot;
        r_vbytes     <= n_vbytes;
        r_slot       <= n_slot;
        r_cnt        <= n_cnt;
        r_ref        <= n_ref;
        r_k          <= n_k;
        r_keep       <= n_keep;
        r_evc        <= n_evc;
        r_ignored    <= n_ignored;
        r_hit        <= n_hit;
    end

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_total      = r_total;
        n_hit_cnt    = r_hit_cnt;
        n_miss_cnt   = r_miss_cnt;
        // Drop the held result once the consumer takes it.
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        n_idx        = r_idx;
        n_pv         = 1'b0;
        n_pa         = r_pa;
        n_item       = r_item;
        n_found      = r_found;
        n_ms         = r_ms;
        n_mrank      = r_mrank;
        n_mbytes     = r_mbytes;
        n_mhandle    = r_mhandle;
        n_free_found = r_free_found;
        n_free       = r_free;
        n_vslot      = r_vslot;
        n_vbytes     = r_vbytes;
        n_slot       = r_slot;
        n_cnt        = r_cnt;
        n_ref        = r_ref;
        n_k          = r_k;
        n_keep       = r_keep;
        n_evc        = r_evc;
        n_ignored    = r_ignored;
        n_hit        = r_hit;

        ram_we    = 1'b0;
        ram_waddr = r_pa;
        ram_wdata = ram_rdata;
        ram_raddr = r_idx[IDX_W-1:0];
        brk_we    = 1'b0;
        brk_waddr = new_rank;
        brk_wdata = ram_rdata.nbytes;
        brk_raddr = r_k[IDX_W-1:0];

        // Issue the next sweep read in the walking states.
        if ((r_state == ST_SCAN || r_state == ST_UPD || r_state == ST_PURGE) &&
            (r_idx < CNT_W'(ENTRIES))) begin
            n_pv  = 1'b1;
            n_pa  = r_idx[IDX_W-1:0];
            n_idx = r_idx + 1'b1;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item       = i_in_data;
                    n_found      = 1'b0;
                    n_free_found = 1'b0;
                    n_cnt        = '0;
                    n_evc        = '0;
                    n_ignored    = 1'b0;
                    n_hit        = 1'b0;
                    n_idx        = '0;
                    if (i_in_data.func == FN_PUT &&
                        {7'b0, i_in_data.item_bytes} > r_cap) begin
                        n_ignored = 1'b1;
                        n_state   = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // Find the matching tag, the first free slot, the oldest entry
                // and the fill count.
                if (r_pv) begin
                    if (cur_v) begin
                        n_cnt = r_cnt + 1'b1;
                        if (!r_found && ram_rdata.tag == r_item.key_tag[TAG_BITS-1:0]) begin
                            n_found   = 1'b1;
                            n_ms      = r_pa;
                            n_mrank   = ram_rdata.rank;
                            n_mbytes  = ram_rdata.nbytes;
                            n_mhandle = ram_rdata.handle;
                        end
                        if (ram_rdata.rank == IDX_W'(ENTRIES - 1)) begin
                            n_vslot  = r_pa;
                            n_vbytes = ram_rdata.nbytes;
                        end
                    end else if (!r_free_found) begin
                        n_free_found = 1'b1;
                        n_free       = r_pa;
                    end
                end
                if (sweep_end) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_idx = '0;
                if (r_item.func == FN_GET) begin
                    if (r_found) begin
                        n_hit_cnt = r_hit_cnt + 1'b1;
                        n_hit     = 1'b1;
                        n_ref     = {1'b0, r_mrank};
                        n_slot    = r_ms;
                        n_state   = ST_UPD;
                    end else begin
                        n_miss_cnt = r_miss_cnt + 1'b1;
                        n_state    = ST_DONE;
                    end
                end else begin
                    // Replace a same-tag entry, else take a free slot, else
                    // evict the oldest entry when every slot is full.
                    n_slot  = r_found ? r_ms : (full ? r_vslot : r_free);
                    n_total = r_total
                            - (r_found ? TOT_W'(r_mbytes) : '0)
                            - (full ? TOT_W'(r_vbytes) : '0)
                            + TOT_W'(r_item.item_bytes);
                    n_evc   = full ? EVC_W'(1) : '0;
                    n_ref   = r_found ? {1'b0, r_mrank} : CNT_W'(ENTRIES);
                    n_keep  = r_cnt - CNT_W'(r_found) - CNT_W'(full) + 1'b1;
                    n_valid[n_slot] = 1'b1;
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                // Rewrite ranks; the touched slot becomes newest.
                if (r_pv) begin
                    if (r_pa == r_slot) begin
                        ram_we         = 1'b1;
                        ram_wdata.rank = '0;
                        if (r_item.func == FN_PUT) begin
                            ram_wdata.tag    = r_item.key_tag[TAG_BITS-1:0];
                            ram_wdata.nbytes = r_item.item_bytes;
                            ram_wdata.handle = r_item.payload_handle[HANDLE_BITS-1:0];
                            brk_we           = 1'b1;
                            brk_waddr        = '0;
                            brk_wdata        = r_item.item_bytes;
                        end
                    end else if (cur_v) begin
                        ram_we         = 1'b1;
                        ram_wdata.rank = new_rank;
                        brk_we         = (r_item.func == FN_PUT);
                    end
                end
                if (sweep_end) begin
                    if (r_item.func == FN_PUT) begin
                        n_k     = r_keep - 1'b1;
                        n_state = ST_EVCHK;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_EVCHK: begin
                // Evict from the oldest rank down while over budget; never the new entry.
                if (CMP_W'(r_total) > CMP_W'(r_cap) && r_k != '0) begin
                    n_state = ST_EVRD;
                end else begin
                    n_idx   = '0;
                    n_state = ST_PURGE;
                end
            end
            ST_EVRD: begin
                n_total = r_total - TOT_W'(brk_rdata);
                n_evc   = (r_evc == '1) ? r_evc : r_evc + 1'b1;
                n_keep  = r_k;
                n_k     = r_k - 1'b1;
                n_state = ST_EVCHK;
            end
            ST_PURGE: begin
                // Retire every slot whose rank fell past the kept count.
                if (r_pv && cur_v && {1'b0, ram_rdata.rank} >= r_keep) begin
                    n_valid[r_pa] = 1'b0;
                end
                if (sweep_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold until the output register is free.
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid         = 1'b1;
                    n_out.hit           = r_hit;
                    n_out.payload_out   = r_hit ? 32'(r_mhandle) : 32'd0;
                    n_out.ignored       = r_ignored;
                    n_out.evicted_count = r_evc;
                    n_out.bytes_in_use  = 32'(r_total);
                    n_out.hit_total     = r_hit_cnt;
                    n_out.miss_total    = r_miss_cnt;
                    n_state             = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `BWLRU_ASSERT_NEXT(a_get_keeps_total, r_state != ST_IDLE && r_item.func == FN_GET, r_total == $past(r_total), "get changed byte total")
    `BWLRU_ASSERT_NOW(a_evict_not_newest, r_state == ST_EVRD, r_k != '0, "eviction reached the newest entry")
    `BWLRU_ASSERT_NOW(a_put_leaves_entry, r_state == ST_DONE && r_item.func == FN_PUT && !r_ignored, $countones(r_valid) != 0, "accepted put left cache empty")
endmodule
`default_nettype wire

### hw/rtl/bwlru_ram.sv
`default_nettype none
module bwlru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire
